// ===== rtl/rotate_scale_nearest_sampler_defines.svh =====
// Assertion macros shared by the sampler modules.
`ifndef ROTATE_SCALE_NEAREST_SAMPLER_DEFINES_SVH
`define ROTATE_SCALE_NEAREST_SAMPLER_DEFINES_SVH

// Checks cons in the same cycle as ante, clocked on clk and quiet in reset.
`define RSN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante.
`define RSN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsn_pkg.sv =====
// Types, constants and register codes of the rotate and scale sampler.
package rsn_pkg;

  localparam int IMG_WIDTH  = 256;
  localparam int IMG_HEIGHT = 256;
  localparam int MEM_DEPTH  = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int COL_IDX_W  = $clog2(IMG_WIDTH);
  localparam int ROW_IDX_W  = $clog2(IMG_HEIGHT);

  // Fixed point: Q8.8 scale times Q1.14 trig gives 22 fraction bits.
  localparam int FRAC_W = 22;
  localparam int SCL_W  = 24;            // scale times an 8-bit offset
  localparam int PROD_W = SCL_W + 1 + 16; // signed product of scaled offset and trig
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - FRAC_W; // integer part after truncation

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_SRC_LEFT   = 3'd0,
    REG_SRC_TOP    = 3'd1,
    REG_SRC_RIGHT  = 3'd2,
    REG_SRC_BOTTOM = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_ROT_COS    = 3'd6,
    REG_ROT_SIN    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] dest_x;
    logic [7:0] dest_y;
    logic [7:0] out_pixel;
    logic       in_bounds;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        src_left;
    logic [7:0]        src_top;
    logic [8:0]        src_right;
    logic [8:0]        src_bottom;
    logic [15:0]       scale_x;
    logic [15:0]       scale_y;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } cfg_t;

  // One classified operation waiting for the back end.
  typedef struct packed {
    logic       is_wr;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] pix;
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } q_head_t;

endpackage

// ===== rtl/rsn_front.sv =====
// Front end: accepts input beats, drops writes outside the image, queues the rest.
`include "rotate_scale_nearest_sampler_defines.svh"

module rsn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rsn_pkg::in_item_t in_data,
  output rsn_pkg::q_head_t  q_head,
  input  logic              q_take
);

  rsn_pkg::op_t                   fifo_r [rsn_pkg::Q_DEPTH];
  logic [rsn_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [rsn_pkg::Q_CNT_W-1:0]    count_r, count_nxt;
  logic                           accept, keep, q_push;
  rsn_pkg::op_t                   op_new;

  assign in_full = (32'(count_r) == rsn_pkg::Q_DEPTH);
  assign accept  = in_push && !in_full;

  // A write whose coordinates fall outside the image has no effect at all.
  always_comb begin
    keep = (in_data.kind == rsn_pkg::KIND_SAMPLE) ||
           ((32'(in_data.pos_x) < rsn_pkg::IMG_WIDTH) &&
            (32'(in_data.pos_y) < rsn_pkg::IMG_HEIGHT));
    op_new.is_wr = (in_data.kind == rsn_pkg::KIND_WRITE);
    op_new.x     = in_data.pos_x;
    op_new.y     = in_data.pos_y;
    op_new.pix   = in_data.pixel_in;
  end

  assign q_push = accept && keep;

  always_comb begin
    count_nxt = count_r;
    if (q_push && !q_take) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && q_take) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      fifo_r[wr_ptr_r] <= op_new;
    end
  end

  assign q_head.vld = (count_r != '0);
  assign q_head.op  = fifo_r[rd_ptr_r];

  `RSN_ASSERT_NOW(a_cnt_max, 1'b1, 32'(count_r) <= rsn_pkg::Q_DEPTH,
                  "queue count above depth")
  `RSN_ASSERT_NOW(a_take_nonempty, q_take, count_r != '0,
                  "back end took from an empty queue")
  `RSN_ASSERT_NEXT(a_cnt_up, q_push && !q_take, count_r == $past(count_r) + 1'b1,
                   "queue count missed a push")

endmodule

// ===== rtl/rsn_back.sv =====
// Back end: coordinate pipeline, source image store and result register.
`include "rotate_scale_nearest_sampler_defines.svh"

module rsn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rsn_pkg::cfg_t      cfg,
  input  rsn_pkg::q_head_t   q_head,
  output logic               q_take,
  output logic               out_empty,
  input  logic               out_pop,
  output rsn_pkg::out_item_t out_data
);

  localparam int PW = rsn_pkg::PROD_W;
  localparam int SW = rsn_pkg::SUM_W;
  localparam int QW = rsn_pkg::Q_W;
  localparam int AW = rsn_pkg::ADDR_W;

  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_vld_r;
  logic wr1_r, wr2_r, wr3_r, wr4_r, wr5_r;
  logic [7:0] x1_r, x2_r, x3_r, x4_r, x5_r, x6_r;
  logic [7:0] y1_r, y2_r, y3_r, y4_r, y5_r, y6_r;
  logic [7:0] pix1_r, pix2_r, pix3_r, pix4_r, pix5_r;

  logic [rsn_pkg::SCL_W-1:0] sxx1_r, syy1_r;
  logic signed [PW-1:0]      p_xc2_r, p_ys2_r, p_xs2_r, p_yc2_r;
  logic [SW-1:0]             fx3_r, fy3_r;
  logic [SW-1:0]             fx_bias, fy_bias;
  logic [QW-1:0]             col4_r, row4_r;
  logic [AW-1:0]             raddr, waddr, addr5_r;
  logic                      ok, ok5_r, ok6_r;
  logic [7:0]                rdata_r;

  logic [7:0] img_mem_r [rsn_pkg::MEM_DEPTH];

  // The whole pipeline moves together; it holds only while a result waits.
  assign adv    = !out_vld_r || out_pop;
  assign q_take = adv && q_head.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= q_head.vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      out_vld_r <= v5_r && !wr5_r;
    end
  end

  // Truncation toward zero: a negative value gets a bias of all fraction ones.
  always_comb begin
    fx_bias = fx3_r[SW-1] ? SW'((1 << rsn_pkg::FRAC_W) - 1) : '0;
    fy_bias = fy3_r[SW-1] ? SW'((1 << rsn_pkg::FRAC_W) - 1) : '0;
  end

  always_comb begin
    raddr = AW'(row4_r[rsn_pkg::ROW_IDX_W-1:0]) * AW'(rsn_pkg::IMG_WIDTH)
          + AW'(col4_r[rsn_pkg::COL_IDX_W-1:0]);
    waddr = AW'(y4_r) * AW'(rsn_pkg::IMG_WIDTH) + AW'(x4_r);
    ok    = !row4_r[QW-1] && !col4_r[QW-1] &&
            ((QW+1)'(row4_r) + 1'b1 < (QW+1)'(cfg.src_bottom)) &&
            ((QW+1)'(col4_r) + 1'b1 < (QW+1)'(cfg.src_right)) &&
            (32'(row4_r) < rsn_pkg::IMG_HEIGHT) &&
            (32'(col4_r) < rsn_pkg::IMG_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr1_r  <= q_head.op.is_wr;
      x1_r   <= q_head.op.x;
      y1_r   <= q_head.op.y;
      pix1_r <= q_head.op.pix;
      sxx1_r <= rsn_pkg::SCL_W'(q_head.op.x) * rsn_pkg::SCL_W'(cfg.scale_x);
      syy1_r <= rsn_pkg::SCL_W'(q_head.op.y) * rsn_pkg::SCL_W'(cfg.scale_y);

      wr2_r   <= wr1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      pix2_r  <= pix1_r;
      p_xc2_r <= $signed({1'b0, sxx1_r}) * cfg.rot_cos;
      p_ys2_r <= $signed({1'b0, syy1_r}) * cfg.rot_sin;
      p_xs2_r <= $signed({1'b0, sxx1_r}) * cfg.rot_sin;
      p_yc2_r <= $signed({1'b0, syy1_r}) * cfg.rot_cos;

      wr3_r  <= wr2_r;
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      pix3_r <= pix2_r;
      fx3_r  <= SW'(p_xc2_r) - SW'(p_ys2_r) + SW'({cfg.src_left, 22'b0});
      fy3_r  <= SW'(p_xs2_r) + SW'(p_yc2_r) + SW'({cfg.src_top, 22'b0});

      wr4_r  <= wr3_r;
      x4_r   <= x3_r;
      y4_r   <= y3_r;
      pix4_r <= pix3_r;
      col4_r <= QW'((fx3_r + fx_bias) >> rsn_pkg::FRAC_W);
      row4_r <= QW'((fy3_r + fy_bias) >> rsn_pkg::FRAC_W);

      wr5_r   <= wr4_r;
      x5_r    <= x4_r;
      y5_r    <= y4_r;
      pix5_r  <= pix4_r;
      ok5_r   <= ok;
      addr5_r <= wr4_r ? waddr : raddr;

      x6_r  <= x5_r;
      y6_r  <= y5_r;
      ok6_r <= ok5_r;
    end
  end

  // Writes and reads hit the store in the order the items arrived.
  always_ff @(posedge clk) begin
    if (adv && v5_r) begin
      if (wr5_r) begin
        img_mem_r[addr5_r] <= pix5_r;
      end else begin
        rdata_r <= img_mem_r[addr5_r];
      end
    end
  end

  assign out_empty          = !out_vld_r;
  assign out_data.dest_x    = x6_r;
  assign out_data.dest_y    = y6_r;
  assign out_data.out_pixel = ok6_r ? rdata_r : 8'd0;
  assign out_data.in_bounds = ok6_r;

  `RSN_ASSERT_NEXT(a_wr_no_result, adv && v5_r && wr5_r, !out_vld_r,
                   "store write produced a result beat")
  `RSN_ASSERT_NEXT(a_rd_result, adv && v5_r && !wr5_r, out_vld_r,
                   "sample lost before the result register")
  `RSN_ASSERT_NEXT(a_hold, out_vld_r && !adv, out_vld_r && $stable(rdata_r) && $stable(ok6_r),
                   "waiting result changed while stalled")

endmodule

// ===== rtl/rotate_scale_nearest_sampler.sv =====
// Top level: configuration registers, front end queue and back end pipeline.
// A sample beat goes through the queue and the pipeline to the result ports.
// Throughput: one item per cycle; the six-stage coordinate and store pipeline
// moves as a whole and holds only while an untaken result waits.
// Writes to the image store give no result beat; writes outside the image are dropped.
// Reset: configuration returns to identity defaults and the queue and pipeline empty;
// the image store is not cleared and holds undefined data until written.
module rotate_scale_nearest_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rsn_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output rsn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);

  rsn_pkg::cfg_t    cfg_r;
  rsn_pkg::q_head_t q_head;
  logic             q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_left   <= 8'd0;
      cfg_r.src_top    <= 8'd0;
      cfg_r.src_right  <= 9'd256;
      cfg_r.src_bottom <= 9'd256;
      cfg_r.scale_x    <= 16'd256;
      cfg_r.scale_y    <= 16'd256;
      cfg_r.rot_cos    <= 16'sd16384;
      cfg_r.rot_sin    <= 16'sd0;
    end else if (cfg_we) begin
      unique case (rsn_pkg::cfg_reg_t'(cfg_idx))
        rsn_pkg::REG_SRC_LEFT:   cfg_r.src_left   <= cfg_wdata[7:0];
        rsn_pkg::REG_SRC_TOP:    cfg_r.src_top    <= cfg_wdata[7:0];
        rsn_pkg::REG_SRC_RIGHT:  cfg_r.src_right  <= cfg_wdata[8:0];
        rsn_pkg::REG_SRC_BOTTOM: cfg_r.src_bottom <= cfg_wdata[8:0];
        rsn_pkg::REG_SCALE_X:    cfg_r.scale_x    <= cfg_wdata;
        rsn_pkg::REG_SCALE_Y:    cfg_r.scale_y    <= cfg_wdata;
        rsn_pkg::REG_ROT_COS:    cfg_r.rot_cos    <= $signed(cfg_wdata);
        rsn_pkg::REG_ROT_SIN:    cfg_r.rot_sin    <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  rsn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_head  (q_head),
    .q_take  (q_take)
  );

  rsn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_head),
    .q_take    (q_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== test/rsn_sample_checker.sv =====
// Watches the sampler's channels, predicts each sample result and compares it.
`timescale 1ns / 100ps

module rsn_sample_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  rsn_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  rsn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 samples_in_flight
);

  logic [7:0]         image_copy [0:rsn_pkg::MEM_DEPTH-1];
  rsn_pkg::cfg_t      settings;
  rsn_pkg::out_item_t pending_samples [$];
  rsn_pkg::out_item_t oldest;

  task automatic report_mismatch(string what, int unsigned seen, int unsigned wanted);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, seen, wanted);
    mismatches++;
  endtask

  // Q.22 values truncate toward zero, so negative fractions round up.
  function automatic longint trunc_q22(longint v);
    if (v >= 0) begin
      return v >>> rsn_pkg::FRAC_W;
    end
    return -((-v) >>> rsn_pkg::FRAC_W);
  endfunction

  function automatic rsn_pkg::out_item_t resample_point(rsn_pkg::in_item_t it);
    rsn_pkg::out_item_t r;
    longint    sx, sy, c, s, dx, dy, fx, fy, col, row, right_lim, bottom_lim;
    sx = settings.scale_x;
    sy = settings.scale_y;
    c  = $signed(settings.rot_cos);
    s  = $signed(settings.rot_sin);
    dx = it.pos_x;
    dy = it.pos_y;
    right_lim  = settings.src_right;
    bottom_lim = settings.src_bottom;
    fx = sx * dx * c - sy * dy * s + (longint'(settings.src_left) <<< rsn_pkg::FRAC_W);
    fy = sx * dx * s + sy * dy * c + (longint'(settings.src_top) <<< rsn_pkg::FRAC_W);
    col = trunc_q22(fx);
    row = trunc_q22(fy);
    r.dest_x    = it.pos_x;
    r.dest_y    = it.pos_y;
    r.out_pixel = 8'd0;
    r.in_bounds = 1'b0;
    if (row >= 0 && col >= 0 && row < bottom_lim - 1 && col < right_lim - 1 &&
        row < rsn_pkg::IMG_HEIGHT && col < rsn_pkg::IMG_WIDTH) begin
      r.in_bounds = 1'b1;
      r.out_pixel = image_copy[row * rsn_pkg::IMG_WIDTH + col];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.src_left   <= 8'd0;
      settings.src_top    <= 8'd0;
      settings.src_right  <= 9'd256;
      settings.src_bottom <= 9'd256;
      settings.scale_x    <= 16'd256;
      settings.scale_y    <= 16'd256;
      settings.rot_cos    <= 16'sd16384;
      settings.rot_sin    <= 16'sd0;
      pending_samples.delete();
      mismatches = 0;
      samples_in_flight <= 0;
    end else begin
      if (!out_empty && out_pop) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("beat with no sample waiting", out_data, 0);
        end else begin
          oldest = pending_samples.pop_front();
          if (out_data.dest_x !== oldest.dest_x)
            report_mismatch("dest_x", out_data.dest_x, oldest.dest_x);
          if (out_data.dest_y !== oldest.dest_y)
            report_mismatch("dest_y", out_data.dest_y, oldest.dest_y);
          if (out_data.out_pixel !== oldest.out_pixel)
            report_mismatch("out_pixel", out_data.out_pixel, oldest.out_pixel);
          if (out_data.in_bounds !== oldest.in_bounds)
            report_mismatch("in_bounds", out_data.in_bounds, oldest.in_bounds);
        end
      end
      if (cfg_we) begin
        unique case (rsn_pkg::cfg_reg_t'(cfg_idx))
          rsn_pkg::REG_SRC_LEFT:   settings.src_left   <= cfg_wdata[7:0];
          rsn_pkg::REG_SRC_TOP:    settings.src_top    <= cfg_wdata[7:0];
          rsn_pkg::REG_SRC_RIGHT:  settings.src_right  <= cfg_wdata[8:0];
          rsn_pkg::REG_SRC_BOTTOM: settings.src_bottom <= cfg_wdata[8:0];
          rsn_pkg::REG_SCALE_X:    settings.scale_x    <= cfg_wdata;
          rsn_pkg::REG_SCALE_Y:    settings.scale_y    <= cfg_wdata;
          rsn_pkg::REG_ROT_COS:    settings.rot_cos    <= cfg_wdata;
          rsn_pkg::REG_ROT_SIN:    settings.rot_sin    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_data.kind == rsn_pkg::KIND_WRITE) begin
          image_copy[in_data.pos_y * rsn_pkg::IMG_WIDTH + in_data.pos_x] = in_data.pixel_in;
        end else begin
          pending_samples.push_back(resample_point(in_data));
        end
      end
      samples_in_flight <= pending_samples.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the sampler testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_top;

  // Only a FILL_SIZE square at the origin is written up front; bounds past
  // that square are kept out of the random phases so reads stay on written data.
  localparam int FILL_SIZE = 16;
  localparam int BND       = FILL_SIZE + 1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  rsn_pkg::in_item_t  in_data = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  rsn_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = 3'd0;
  logic [15:0]        cfg_wdata = 16'd0;

  int mismatches;
  int samples_in_flight;
  int gap_odds = 0;
  bit rx_calm = 1'b0;

  rotate_scale_nearest_sampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rsn_sample_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data           (in_data),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data          (out_data),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .samples_in_flight (samples_in_flight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[rotate_scale_nearest_sampler] ERROR");
    $finish;
  end

  // Result side: bursts of stalls between stretches of taking every beat.
  initial begin
    forever begin
      if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic rsn_pkg::in_item_t make_item(logic k, int x, int y, int p);
    rsn_pkg::in_item_t it;
    it.kind     = k;
    it.pos_x    = 8'(x);
    it.pos_y    = 8'(y);
    it.pixel_in = 8'(p);
    return it;
  endfunction

  function automatic rsn_pkg::in_item_t random_item();
    rsn_pkg::in_item_t it;
    it.kind = ($urandom_range(0, 9) < 7) ? rsn_pkg::KIND_SAMPLE : rsn_pkg::KIND_WRITE;
    // Small offsets keep samples near the origin when the scale is large.
    if ($urandom_range(0, 3) == 0) begin
      it.pos_x = 8'($urandom_range(0, 15));
      it.pos_y = 8'($urandom_range(0, 15));
    end else begin
      it.pos_x = 8'($urandom_range(0, 255));
      it.pos_y = 8'($urandom_range(0, 255));
    end
    it.pixel_in = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic rsn_pkg::cfg_t make_settings(int left, int top, int right, int bottom,
                                                  int sx, int sy, int c, int s);
    rsn_pkg::cfg_t v;
    v.src_left   = 8'(left);
    v.src_top    = 8'(top);
    v.src_right  = 9'(right);
    v.src_bottom = 9'(bottom);
    v.scale_x    = 16'(sx);
    v.scale_y    = 16'(sy);
    v.rot_cos    = 16'(c);
    v.rot_sin    = 16'(s);
    return v;
  endfunction

  function automatic int random_bound();
    int pick;
    pick = $urandom_range(0, 7);
    unique case (pick)
      0: return 0;
      1: return 1;
      2: return BND;
      default: return $urandom_range(0, BND);
    endcase
  endfunction

  function automatic int random_scale();
    int pick;
    pick = $urandom_range(0, 3);
    unique case (pick)
      0, 1: return $urandom_range(0, 512);
      2: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic rsn_pkg::cfg_t random_settings();
    return make_settings($urandom_range(0, 31), $urandom_range(0, 31),
                         random_bound(), random_bound(), random_scale(), random_scale(),
                         int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_item(rsn_pkg::in_item_t it);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Holds the sender until every sample result is back and the pipeline is empty.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (samples_in_flight != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(rsn_pkg::cfg_reg_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(rsn_pkg::cfg_t v);
    write_reg(rsn_pkg::REG_SRC_LEFT,   {8'd0, v.src_left});
    write_reg(rsn_pkg::REG_SRC_TOP,    {8'd0, v.src_top});
    write_reg(rsn_pkg::REG_SRC_RIGHT,  {7'd0, v.src_right});
    write_reg(rsn_pkg::REG_SRC_BOTTOM, {7'd0, v.src_bottom});
    write_reg(rsn_pkg::REG_SCALE_X,    v.scale_x);
    write_reg(rsn_pkg::REG_SCALE_Y,    v.scale_y);
    write_reg(rsn_pkg::REG_ROT_COS,    v.rot_cos);
    write_reg(rsn_pkg::REG_ROT_SIN,    v.rot_sin);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(rsn_pkg::cfg_t v, int count, int odds);
    settle();
    load_settings(v);
    gap_odds = odds;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the square at the origin; the bounds of the run phases keep every read inside it.
    for (int y = 0; y < FILL_SIZE; y++) begin
      for (int x = 0; x < FILL_SIZE; x++) begin
        send_item(make_item(rsn_pkg::KIND_WRITE, x, y, $urandom_range(0, 255)));
      end
    end

    // Identity mapping straight after reset: corners, edges and fresh writes.
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 0, 0, 8'hFF));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 15, 15, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 255, 0, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 0, 255, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 255, 255, 0));
    send_item(make_item(rsn_pkg::KIND_WRITE, 0, 0, 8'hFF));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 0, 0, 0));
    send_item(make_item(rsn_pkg::KIND_WRITE, 254, 254, 8'h00));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 254, 254, 8'hFF));
    send_item(make_item(rsn_pkg::KIND_WRITE, 255, 255, 8'hAA));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 255, 255, 0));
    send_item(make_item(rsn_pkg::KIND_WRITE, 85, 170, 8'h55));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 85, 170, 0));

    // Half scale mirrored: minus one half truncates to zero and stays inside.
    settle();
    load_settings(make_settings(0, 0, 256, 256, 128, 128, -16384, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 1, 1, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 0, 0, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 2, 0, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 3, 3, 0));
    send_item(make_item(rsn_pkg::KIND_SAMPLE, 1, 0, 0));

    run_phase(make_settings(0, 0, BND, BND, 256, 256, 16384, 0), 120, 6);
    run_phase(make_settings(15, 0, BND, BND, 256, 256, 0, 16384), 120, 3);
    run_phase(make_settings(15, 15, BND, BND, 256, 256, -16384, 0), 120, 0);
    run_phase(make_settings(0, 15, BND, BND, 256, 256, 0, -16384), 100, 8);
    run_phase(make_settings(8, 0, $urandom_range(1, BND), BND, 181, 181, 11585, 11585),
              120, 4);
    run_phase(make_settings($urandom_range(0, 15), $urandom_range(0, 15), BND, BND,
                            0, 0, 16384, 0), 60, 5);
    run_phase(make_settings(0, 0, BND, BND, 65535, 65535, 16384, 16384), 60, 5);
    run_phase(make_settings(0, 0, 0, BND, 256, 256, 16384, 0), 40, 4);
    run_phase(make_settings(0, 0, 1, 1, 64, 64, 16384, 0), 40, 4);
    run_phase(make_settings(10, 10, BND, 0, 64, 64, 16384, 0), 40, 4);
    run_phase(make_settings(15, 15, BND, BND, 128, 128, -16384, 16384), 80, 6);
    repeat (5) run_phase(random_settings(), 70, $urandom_range(0, 6));

    // Last part runs flat out on both sides.
    settle();
    rx_calm = 1'b1;
    run_phase(make_settings($urandom_range(0, 8), $urandom_range(0, 8), BND, BND,
                            $urandom_range(32, 256), $urandom_range(32, 256),
                            int'($urandom_range(0, 32768)) - 16384,
                            int'($urandom_range(0, 32768)) - 16384), 150, 0);

    in_push <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (samples_in_flight != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && samples_in_flight == 0) begin
      $display("[rotate_scale_nearest_sampler] OK");
    end else begin
      $display("[rotate_scale_nearest_sampler] ERROR");
    end
    $finish;
  end

endmodule
